// ===== rtl/shs_pkg.sv =====
package shs_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic {
        ACT_APPEND = 1'b0,
        ACT_FINISH = 1'b1
    } action_t;

    typedef struct packed {
        logic       shift_en;
        logic       step_en;
        logic [7:0] byte_val;
    } sched_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } round_ctl_t;

    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
    localparam logic [5:0]  LAST_POS      = 6'd63;
    localparam logic [5:0]  LAST_ROUND    = 6'd63;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BLOCK_BITS    = 64'd512;

    localparam hash_t IV_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== rtl/shs_msg_sched.sv =====
module shs_msg_sched (
    input  logic               clk,
    input  shs_pkg::sched_ctl_t ctl,
    output shs_pkg::word_t     w_cur
);

    // 16-word window, W[0] in the top word; bytes enter at the bottom,
    // so after 64 bytes the block sits big-endian with byte 0 on top
    logic [511:0]   win_reg;
    shs_pkg::word_t w_new;

    assign w_cur = win_reg[511:480];
    assign w_new = shs_pkg::small_sigma1(win_reg[63:32]) + win_reg[223:192]
                 + shs_pkg::small_sigma0(win_reg[479:448]) + win_reg[511:480];

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            win_reg <= {win_reg[503:0], ctl.byte_val};
        end
        else if (ctl.step_en)
        begin
            win_reg <= {win_reg[479:0], w_new};
        end
    end

endmodule

// ===== rtl/shs_round.sv =====
module shs_round (
    input  logic                clk,
    input  shs_pkg::round_ctl_t ctl,
    input  shs_pkg::hash_t      chain,
    input  shs_pkg::word_t      k,
    input  shs_pkg::word_t      w,
    output shs_pkg::hash_t      v
);

    shs_pkg::hash_t v_reg;
    shs_pkg::word_t t1;
    shs_pkg::word_t t2;

    assign v = v_reg;

    assign t1 = v_reg[7] + shs_pkg::big_sigma1(v_reg[4])
              + shs_pkg::choose(v_reg[4], v_reg[5], v_reg[6]) + k + w;
    assign t2 = shs_pkg::big_sigma0(v_reg[0]) + shs_pkg::majority(v_reg[0], v_reg[1], v_reg[2]);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg <= chain;
        end
        else if (ctl.step)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

endmodule

// ===== rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 over a byte stream, one round per cycle.
// Input channel (in_valid/in_ready): action 0 appends data_byte to the
// message, action 1 finishes it. Output channel (out_valid/out_ready):
// eight items per finish, digest_word H0..H7 with word_index 0..7 and
// last_word on the eighth.
// An append is taken in ST_IDLE; the byte that completes a 64-byte block
// keeps in_ready low through the 64 rounds and the chaining add.
// A finish shifts padding and length into the block one byte per cycle
// through the byte path, then compresses; with 56 or more bytes pending
// the length no longer fits and an extra block is padded and compressed.
// in_ready stays low until all eight digest words are taken; a stalled
// receiver simply holds the current word. After the last word the chain
// returns to the initial vector and a new message starts.
// Reset loads the initial vector and clears byte count and length.
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shs_pkg::state_t     state_reg, state_next;
    logic [5:0]          pos_reg, pos_next;
    logic [63:0]         len_reg, len_next;
    logic [5:0]          rnd_reg, rnd_next;
    logic                fin_reg, fin_next;
    logic                final_reg, final_next;
    logic [2:0]          widx_reg, widx_next;
    shs_pkg::hash_t      chain_reg, chain_next;

    shs_pkg::sched_ctl_t sched_ctl;
    shs_pkg::round_ctl_t round_ctl;
    shs_pkg::word_t      w_cur;
    shs_pkg::hash_t      v;

    shs_msg_sched u_sched (
        .clk   (clk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    shs_round u_round (
        .clk   (clk),
        .ctl   (round_ctl),
        .chain (chain_reg),
        .k     (shs_pkg::ROUND_K[rnd_reg]),
        .w     (w_cur),
        .v     (v)
    );

    assign digest_word = chain_reg[0];
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == shs_pkg::LAST_WORD_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shs_pkg::ST_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            final_reg <= 1'b0;
            widx_reg  <= '0;
            chain_reg <= shs_pkg::IV_HASH;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            final_reg <= final_next;
            widx_reg  <= widx_next;
            chain_reg <= chain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        final_next = final_reg;
        widx_next  = widx_reg;
        chain_next = chain_reg;
        sched_ctl  = '0;
        round_ctl  = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            shs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sched_ctl.shift_en = 1'b1;
                    pos_next           = pos_reg + 6'd1;
                    if (action == shs_pkg::ACT_FINISH)
                    begin
                        sched_ctl.byte_val = shs_pkg::PAD_MARK;
                        len_next   = len_reg + {55'd0, pos_reg, 3'd0};
                        fin_next   = 1'b1;
                        // length fits behind the marker only below byte 56
                        final_next = (pos_reg < shs_pkg::LEN_FIELD_POS);
                        state_next = shs_pkg::ST_PAD;
                    end
                    else
                    begin
                        sched_ctl.byte_val = data_byte;
                        if (pos_reg == shs_pkg::LAST_POS)
                        begin
                            len_next = len_reg + shs_pkg::BLOCK_BITS;
                        end
                    end
                    if (pos_reg == shs_pkg::LAST_POS)
                    begin
                        round_ctl.load = 1'b1;
                        rnd_next       = '0;
                        state_next     = shs_pkg::ST_ROUND;
                    end
                end
            end

            shs_pkg::ST_PAD:
            begin
                sched_ctl.shift_en = 1'b1;
                pos_next           = pos_reg + 6'd1;
                if (final_reg && (pos_reg >= shs_pkg::LEN_FIELD_POS))
                begin
                    sched_ctl.byte_val = len_reg[63:56];
                    len_next           = {len_reg[55:0], 8'd0};
                end
                else
                begin
                    sched_ctl.byte_val = 8'd0;
                end
                if (pos_reg == shs_pkg::LAST_POS)
                begin
                    round_ctl.load = 1'b1;
                    rnd_next       = '0;
                    state_next     = shs_pkg::ST_ROUND;
                end
            end

            shs_pkg::ST_ROUND:
            begin
                round_ctl.step    = 1'b1;
                sched_ctl.step_en = 1'b1;
                rnd_next          = rnd_reg + 6'd1;
                if (rnd_reg == shs_pkg::LAST_ROUND)
                begin
                    state_next = shs_pkg::ST_UPDATE;
                end
            end

            shs_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v[i];
                end
                if (!fin_reg)
                begin
                    state_next = shs_pkg::ST_IDLE;
                end
                else if (final_reg)
                begin
                    widx_next  = '0;
                    state_next = shs_pkg::ST_OUT;
                end
                else
                begin
                    // extra block carries only zeros and the length
                    final_next = 1'b1;
                    state_next = shs_pkg::ST_PAD;
                end
            end

            shs_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    widx_next = widx_reg + 3'd1;
                    for (int i = 0; i < 7; i++)
                    begin
                        chain_next[i] = chain_reg[i + 1];
                    end
                    if (widx_reg == shs_pkg::LAST_WORD_IDX)
                    begin
                        chain_next = shs_pkg::IV_HASH;
                        widx_next  = '0;
                        pos_next   = '0;
                        len_next   = '0;
                        fin_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = shs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = shs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/shs_checker.sv =====
module shs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        action,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // stalled digest item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest item changed while stalled");

    // no new item taken while digest words are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
    else $error("input ready during digest output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word flag disagrees with word_index");

    // words come out in order without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

    // a finish item always starts padding, never an immediate result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action |=> !in_ready && !out_valid)
    else $error("finish item not followed by padding");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
